>>> rtl/pretrigger_pulse_capture_assert.svh
// pretrigger_pulse_capture_assert.svh: assertion macros for the capture block checks
// no dependencies; included by files that hold concurrent assertions
`ifndef PRETRIGGER_PULSE_CAPTURE_ASSERT_SVH
`define PRETRIGGER_PULSE_CAPTURE_ASSERT_SVH

// same-cycle implication
`define PPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppc check failed");

// next-cycle implication
`define PPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppc check failed");

`endif

>>> rtl/ppc_pkg.sv
// ppc_pkg: types and constants of the pretrigger pulse capture block
// no dependencies; used by ppc_baseline, pretrigger_pulse_capture and ppc_checker
package ppc_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 8;
   localparam int ACC_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int REQ_BITS    = 24;
   localparam int RSP_BITS    = 176;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [1:0] PH_ARMING = 2'd0;
   localparam logic [1:0] PH_ARMED  = 2'd1;
   localparam logic [1:0] PH_POST   = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_TRIGGER_DELTA = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_WARMUP_LENGTH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FAST_SHIFT    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SLOW_SHIFT    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CONSECUTIVE   = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_DECIDE,
      ST_COPY,
      ST_READ,
      ST_REPLY
   } seq_state_type;

   typedef struct packed {
      logic       seed;
      logic       track;
      logic [3:0] shift;
   } filt_ctl_type;

endpackage

>>> rtl/ppc_baseline.sv
// ppc_baseline: baseline filter step (seed, then first-order tracking step)
// depends on ppc_pkg
module ppc_baseline (
   input  logic [ppc_pkg::ACC_BITS-1:0]    acc,
   input  logic [ppc_pkg::SAMPLE_BITS-1:0] sample,
   input  ppc_pkg::filt_ctl_type           ctl,
   output logic [ppc_pkg::ACC_BITS-1:0]    acc_next
);

   logic [ppc_pkg::ACC_BITS-1:0] target;
   logic [ppc_pkg::ACC_BITS-1:0] start;
   logic [ppc_pkg::ACC_BITS-1:0] diff;
   logic [ppc_pkg::ACC_BITS:0]   down;
   logic [ppc_pkg::ACC_BITS:0]   round;

   always_comb begin
      target = {sample, {ppc_pkg::FRAC_BITS{1'b0}}};
      start  = ctl.seed ? target : acc;
      round  = (ppc_pkg::ACC_BITS+1)'((1 << ctl.shift) - 1);
      diff   = '0;
      down   = '0;
      acc_next = start;
      if (ctl.track) begin
         if (target >= start) begin
            diff     = (target - start) >> ctl.shift;
            acc_next = start + diff;
         end else begin
            down     = ({1'b0, start - target} + round) >> ctl.shift;
            acc_next = start - down[ppc_pkg::ACC_BITS-1:0];
         end
      end
   end

endmodule

>>> rtl/pretrigger_pulse_capture.sv
// pretrigger_pulse_capture: pre-trigger ring buffer waveform capture, top level
// depends on ppc_pkg and ppc_baseline
//
// A sample transfer (tuser 0) is written into the pre-trigger ring and updates
// min, max, the baseline filter and the trigger logic. For the sample that
// triggers, the ring is copied oldest first into the capture store one entry a
// cycle through the single ring read port. A read transfer (tuser 1) includes
// the capture store read. One item is in work at a time; the result register
// lets the next item start while the previous result waits. After reset a
// clearing pass over the RING_DEPTH + TAIL_DEPTH store addresses zeroes both
// memories before the first item is taken; configuration writes are taken at
// any time.
module pretrigger_pulse_capture #(
   parameter int RING_DEPTH = 256,
   parameter int TAIL_DEPTH = 768
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = sample[11:0], arm[12], read_index[22:13], zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ppc_pkg::REQ_BITS-1:0]      req_tdata,
   input  logic                              req_tuser,   // opcode
   // response: tdata = phase, capture_ready, baseline_now, lowest_sample,
   // highest_sample, event_number, samples_seen, trigger_sample,
   // trigger_baseline, trigger_count_at, read_data, zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ppc_pkg::RSP_BITS-1:0]      rsp_tdata,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ppc_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int TOTAL = RING_DEPTH + TAIL_DEPTH;
   localparam int RIDX  = $clog2(RING_DEPTH);
   localparam int SIDX  = $clog2(TOTAL);
   localparam int CCW   = $clog2(RING_DEPTH + 1);
   localparam int POSW  = $clog2(TOTAL + 1);
   localparam int SB    = ppc_pkg::SAMPLE_BITS;
   localparam int AB    = ppc_pkg::ACC_BITS;

   // configuration registers
   logic [11:0] delta_ff;
   logic [15:0] warm_len_ff;
   logic [3:0]  fast_ff;
   logic [3:0]  slow_ff;
   logic [7:0]  needed_ff;

   // sequencer
   ppc_pkg::seq_state_type state_ff, state_in;

   // held request item
   logic          op_ff, op_in;
   logic [SB-1:0] s_ff, s_in;
   logic          arm_ff, arm_in;
   logic [9:0]    idx_ff, idx_in;

   // block state
   logic [RIDX-1:0] wp_ff, wp_in;
   logic [RIDX-1:0] rptr_ff, rptr_in;
   logic [CCW-1:0]  copy_ff, copy_in;
   logic [SIDX-1:0] clr_ff, clr_in;
   logic [POSW-1:0] pos_ff, pos_in;
   logic [15:0]     wc_ff, wc_in;
   logic [7:0]      run_ff, run_in;
   logic [AB-1:0]   acc_ff, acc_in;
   logic            seeded_ff, seeded_in;
   logic [1:0]      phase_ff, phase_in;
   logic            ready_ff, ready_in;
   logic [31:0]     event_ff, event_in;
   logic [31:0]     count_ff, count_in;
   logic [SB-1:0]   min_ff, min_in;
   logic [SB-1:0]   max_ff, max_in;
   logic [SB-1:0]   trig_s_ff, trig_s_in;
   logic [SB-1:0]   trig_b_ff, trig_b_in;
   logic [31:0]     trig_n_ff, trig_n_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ppc_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   // memories
   logic [SB-1:0]   ring_mem [RING_DEPTH];
   logic [SB-1:0]   store_mem [TOTAL];
   logic [SB-1:0]   ring_rd_ff;
   logic [SB-1:0]   store_rd_ff;
   logic            ring_we, ring_re, store_we, store_re;
   logic [RIDX-1:0] ring_waddr, ring_raddr;
   logic [SIDX-1:0] store_waddr, store_raddr;
   logic [SB-1:0]   ring_wdata, store_wdata;

   // filter and decision terms
   ppc_pkg::filt_ctl_type filt_ctl;
   logic [AB-1:0]  filt_acc;
   logic [SB-1:0]  base;
   logic [SB-1:0]  ub;
   logic           warm;
   logic           near;
   logic           outside;
   logic [7:0]     run_next;
   logic           trigger;
   logic           accept;
   logic           load_rsp;
   logic           idx_ok;
   logic [15:0]    wc_next;
   logic [1:0]     phase_next;
   logic [POSW-1:0] pos_next;

   assign accept     = req_tvalid && req_tready;
   assign load_rsp   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign idx_ok     = 32'(idx_ff) < TOTAL;

   // configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff    <= 12'd32;
         warm_len_ff <= 16'd2048;
         fast_ff     <= 4'd4;
         slow_ff     <= 4'd8;
         needed_ff   <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ppc_pkg::REG_TRIGGER_DELTA: delta_ff    <= csr_data[11:0];
            ppc_pkg::REG_WARMUP_LENGTH: warm_len_ff <= csr_data;
            ppc_pkg::REG_FAST_SHIFT:    fast_ff     <= csr_data[3:0];
            ppc_pkg::REG_SLOW_SHIFT:    slow_ff     <= csr_data[3:0];
            ppc_pkg::REG_CONSECUTIVE:   needed_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // baseline filter: seed on the first sample, fast in warmup, slow when armed and near
   assign base = seeded_ff ? acc_ff[AB-1:ppc_pkg::FRAC_BITS] : s_ff;
   assign warm = wc_ff < warm_len_ff;
   assign near = ({2'b0, s_ff} + 14'(delta_ff >> 1) >= {2'b0, base})
              && ({2'b0, s_ff} <= {2'b0, base} + {1'b0, delta_ff, 1'b0});

   always_comb begin
      filt_ctl.seed  = !seeded_ff;
      filt_ctl.track = warm || (phase_ff == ppc_pkg::PH_ARMED && near);
      filt_ctl.shift = warm ? fast_ff : slow_ff;
   end

   ppc_baseline u_baseline (
      .acc      (acc_ff),
      .sample   (s_ff),
      .ctl      (filt_ctl),
      .acc_next (filt_acc)
   );

   // trigger decision works on the baseline after the update
   assign ub       = acc_ff[AB-1:ppc_pkg::FRAC_BITS];
   assign outside  = ({1'b0, s_ff} + {1'b0, delta_ff} < {1'b0, ub})
                  || ({1'b0, s_ff} > {1'b0, ub} + {1'b0, delta_ff});
   assign run_next = (phase_ff == ppc_pkg::PH_ARMED) ? (outside ? run_ff + 8'd1 : 8'd0)
                                                     : run_ff;
   assign trigger  = (phase_ff == ppc_pkg::PH_ARMED) && (run_next >= needed_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppc_pkg::ST_CLEAR:  if (32'(clr_ff) == TOTAL - 1) state_in = ppc_pkg::ST_IDLE;
         ppc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == ppc_pkg::OP_READ) ? ppc_pkg::ST_READ
                                                          : ppc_pkg::ST_CALC;
            end
         end
         ppc_pkg::ST_CALC:   state_in = ppc_pkg::ST_DECIDE;
         ppc_pkg::ST_DECIDE: state_in = trigger ? ppc_pkg::ST_COPY : ppc_pkg::ST_REPLY;
         ppc_pkg::ST_COPY:   if (32'(copy_ff) == RING_DEPTH) state_in = ppc_pkg::ST_REPLY;
         ppc_pkg::ST_READ:   state_in = ppc_pkg::ST_REPLY;
         ppc_pkg::ST_REPLY:  if (load_rsp) state_in = ppc_pkg::ST_IDLE;
         default:            state_in = ppc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and memory ports
   always_comb begin
      req_tready  = 1'b0;
      ring_we     = 1'b0;
      ring_waddr  = wp_ff;
      ring_wdata  = s_ff;
      ring_re     = 1'b0;
      ring_raddr  = rptr_ff;
      store_we    = 1'b0;
      store_waddr = SIDX'(pos_ff);
      store_wdata = s_ff;
      store_re    = 1'b0;
      store_raddr = SIDX'(idx_ff);
      unique case (state_ff)
         ppc_pkg::ST_CLEAR: begin
            store_we    = 1'b1;
            store_waddr = clr_ff;
            store_wdata = '0;
            ring_we     = 32'(clr_ff) < RING_DEPTH;
            ring_waddr  = clr_ff[RIDX-1:0];
            ring_wdata  = '0;
         end
         ppc_pkg::ST_IDLE: req_tready = 1'b1;
         ppc_pkg::ST_CALC: ring_we = 1'b1;
         ppc_pkg::ST_DECIDE: begin
            // post-trigger sample into the store
            store_we = !trigger && phase_ff == ppc_pkg::PH_POST && 32'(pos_ff) < TOTAL;
         end
         ppc_pkg::ST_COPY: begin
            // read ring entry n while entry n-1 lands in the store
            ring_re     = 32'(copy_ff) < RING_DEPTH;
            store_we    = copy_ff != '0;
            store_waddr = SIDX'(copy_ff - CCW'(1));
            store_wdata = ring_rd_ff;
         end
         ppc_pkg::ST_READ:  store_re = 1'b1;
         ppc_pkg::ST_REPLY: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
      if (ring_re) ring_rd_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_waddr] <= store_wdata;
      if (store_re) store_rd_ff <= store_mem[store_raddr];
   end

   // datapath next values
   always_comb begin
      op_in = op_ff;   s_in = s_ff;   arm_in = arm_ff;   idx_in = idx_ff;
      wp_in = wp_ff;   rptr_in = rptr_ff;   copy_in = copy_ff;   pos_in = pos_ff;
      wc_in = wc_ff;   run_in = run_ff;   acc_in = acc_ff;   seeded_in = seeded_ff;
      phase_in = phase_ff;   ready_in = ready_ff;   event_in = event_ff;
      count_in = count_ff;   min_in = min_ff;   max_in = max_ff;
      trig_s_in = trig_s_ff;   trig_b_in = trig_b_ff;   trig_n_in = trig_n_ff;
      clr_in = clr_ff + SIDX'(1);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wc_next    = wc_ff;
      phase_next = phase_ff;
      pos_next   = pos_ff;

      case (state_ff)
         ppc_pkg::ST_IDLE: begin
            if (accept) begin
               op_in  = req_tuser;
               s_in   = req_tdata[11:0];
               arm_in = req_tdata[12];
               idx_in = req_tdata[22:13];
            end
         end
         ppc_pkg::ST_CALC: begin
            wp_in     = (wp_ff == RIDX'(RING_DEPTH - 1)) ? '0 : wp_ff + RIDX'(1);
            count_in  = count_ff + 32'd1;
            seeded_in = 1'b1;
            acc_in    = filt_acc;
            if (warm) begin
               wc_next    = wc_ff + 16'd1;
               phase_next = ppc_pkg::PH_ARMING;
            end
            if (arm_ff) begin
               ready_in   = 1'b0;
               phase_next = ppc_pkg::PH_ARMED;
               wc_next    = warm_len_ff;
               min_in     = s_ff;
               max_in     = s_ff;
            end else begin
               if (s_ff < min_ff) min_in = s_ff;
               if (s_ff > max_ff) max_in = s_ff;
            end
            if (wc_next >= warm_len_ff && phase_next == ppc_pkg::PH_ARMING) begin
               phase_next = ppc_pkg::PH_ARMED;
            end
            wc_in    = wc_next;
            phase_in = phase_next;
         end
         ppc_pkg::ST_DECIDE: begin
            run_in = run_next;
            if (trigger) begin
               pos_in    = POSW'(RING_DEPTH);
               trig_s_in = s_ff;
               trig_b_in = ub;
               trig_n_in = count_ff;
               phase_in  = ppc_pkg::PH_POST;
               run_in    = '0;
               copy_in   = '0;
               rptr_in   = wp_ff;
            end else if (phase_ff == ppc_pkg::PH_POST) begin
               if (32'(pos_ff) < TOTAL) pos_next = pos_ff + POSW'(1);
               pos_in = pos_next;
               if (32'(pos_next) >= TOTAL) begin
                  event_in = event_ff + 32'd1;
                  ready_in = 1'b1;
                  phase_in = ppc_pkg::PH_DONE;
               end
            end
         end
         ppc_pkg::ST_COPY: begin
            copy_in = copy_ff + CCW'(1);
            if (32'(copy_ff) < RING_DEPTH) begin
               rptr_in = (rptr_ff == RIDX'(RING_DEPTH - 1)) ? '0 : rptr_ff + RIDX'(1);
            end
         end
         ppc_pkg::ST_REPLY: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0,
                  (op_ff == ppc_pkg::OP_READ && idx_ok) ? store_rd_ff : {SB{1'b0}},
                  trig_n_ff, trig_b_ff, trig_s_ff, count_ff, event_ff,
                  max_ff, min_ff, acc_ff[AB-1:ppc_pkg::FRAC_BITS], ready_ff, phase_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      s_ff        <= s_in;
      arm_ff      <= arm_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ppc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         rptr_ff      <= '0;
         copy_ff      <= '0;
         pos_ff       <= '0;
         wc_ff        <= '0;
         run_ff       <= '0;
         acc_ff       <= '0;
         seeded_ff    <= 1'b0;
         phase_ff     <= ppc_pkg::PH_ARMING;
         ready_ff     <= 1'b0;
         event_ff     <= '0;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         trig_s_ff    <= '0;
         trig_b_ff    <= '0;
         trig_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rptr_ff      <= rptr_in;
         copy_ff      <= copy_in;
         pos_ff       <= pos_in;
         wc_ff        <= wc_in;
         run_ff       <= run_in;
         acc_ff       <= acc_in;
         seeded_ff    <= seeded_in;
         phase_ff     <= phase_in;
         ready_ff     <= ready_in;
         event_ff     <= event_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         trig_s_ff    <= trig_s_in;
         trig_b_ff    <= trig_b_in;
         trig_n_ff    <= trig_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/ppc_checker.sv
// ppc_checker: port-level checks of the capture block, bound to the top level
// depends on pretrigger_pulse_capture_assert.svh and ppc_pkg
`include "pretrigger_pulse_capture_assert.svh"

module ppc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [ppc_pkg::RSP_BITS-1:0] rsp_tdata
);

   `PPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `PPC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `PPC_ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   `PPC_ASSERT_IMPLY(a_rsp_after_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind pretrigger_pulse_capture ppc_checker u_ppc_checker (.*);
